### sv/tsip_pkg.sv
package tsip_pkg;

  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_ETX = 8'h03;

  // report ids
  localparam logic [7:0] RID_INIT   = 8'h45;
  localparam logic [7:0] RID_HEALTH = 8'h46;
  localparam logic [7:0] RID_SATSEL = 8'h44;
  localparam logic [7:0] RID_ALLSV  = 8'h6D;
  localparam logic [7:0] RID_MODE   = 8'h82;
  localparam logic [7:0] RID_TIME   = 8'h41;
  localparam logic [7:0] RID_VEL    = 8'h56;
  localparam logic [7:0] RID_POS    = 8'h83;

  // field kinds
  localparam logic [3:0] K_INIT   = 4'd0;
  localparam logic [3:0] K_STATUS = 4'd1;
  localparam logic [3:0] K_ERROR  = 4'd2;
  localparam logic [3:0] K_MODE   = 4'd3;
  localparam logic [3:0] K_SAT    = 4'd4;
  localparam logic [3:0] K_DOP    = 4'd5;
  localparam logic [3:0] K_TOW    = 4'd6;
  localparam logic [3:0] K_WEEK   = 4'd7;
  localparam logic [3:0] K_UTC    = 4'd8;
  localparam logic [3:0] K_VEL    = 4'd9;
  localparam logic [3:0] K_POSN   = 4'd10;

  localparam logic [31:0] TOW_LIMIT = 32'h4913A800;

  // one field to emit: where its bytes sit in the frame store
  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] idx;
    logic [7:0] pos;
    logic [3:0] len;
    logic       last;
  } fdesc_t;

endpackage

### sv/tsip_field_map.sv
module tsip_field_map #(
  parameter int MAX_SATS = 6
) (
  input  logic [7:0]     rid,
  input  logic [8:0]     cnt,
  input  logic [4:0]     fidx,
  input  logic [3:0]     sat_k,
  input  logic           tow_ok,
  output tsip_pkg::fdesc_t desc,
  output logic [4:0]     n_fields
);

  localparam logic [4:0] MAXS = 5'(MAX_SATS);

  logic [4:0] s;
  logic [4:0] dd;
  logic [4:0] n;

  always_comb begin
    desc = '0;
    n    = '0;
    s    = '0;
    dd   = '0;
    case (rid)
      tsip_pkg::RID_INIT: begin
        if (cnt == 9'd10) n = 5'd1;
        desc.kind = tsip_pkg::K_INIT;
      end
      tsip_pkg::RID_HEALTH: begin
        if (cnt == 9'd2) n = 5'd2;
        if (fidx == 5'd0) begin
          desc.kind = tsip_pkg::K_STATUS;
        end else begin
          desc.kind = tsip_pkg::K_ERROR;
          desc.pos  = 8'd1;
          desc.len  = 4'd1;
        end
      end
      tsip_pkg::RID_SATSEL: begin
        if (cnt == 9'd21) n = 5'd5 + MAXS;
        if (fidx == 5'd0) begin
          desc.kind = tsip_pkg::K_MODE;
        end else if (fidx <= MAXS) begin
          s         = fidx - 5'd1;
          desc.kind = tsip_pkg::K_SAT;
          desc.idx  = s[2:0];
          desc.pos  = 8'(s) + 8'd1;
          desc.len  = (s < 5'd4) ? 4'd1 : 4'd0;
        end else begin
          dd        = fidx - 5'd1 - MAXS;
          desc.kind = tsip_pkg::K_DOP;
          desc.idx  = dd[2:0];
          desc.pos  = 8'd5 + (8'(dd) << 2);
          desc.len  = 4'd4;
        end
      end
      tsip_pkg::RID_ALLSV: begin
        if (cnt >= 9'd17) n = 5'd5 + MAXS;
        if (fidx == 5'd0) begin
          desc.kind = tsip_pkg::K_MODE;
        end else if (fidx <= 5'd4) begin
          dd        = fidx - 5'd1;
          desc.kind = tsip_pkg::K_DOP;
          desc.idx  = dd[2:0];
          desc.pos  = 8'd1 + (8'(dd) << 2);
          desc.len  = 4'd4;
        end else begin
          s         = fidx - 5'd5;
          desc.kind = tsip_pkg::K_SAT;
          desc.idx  = s[2:0];
          desc.pos  = 8'd17 + 8'(s);
          desc.len  = (s < 5'(sat_k)) ? 4'd1 : 4'd0;
        end
      end
      tsip_pkg::RID_MODE: begin
        if (cnt >= 9'd1) n = 5'd1;
        desc.kind = tsip_pkg::K_MODE;
      end
      tsip_pkg::RID_TIME: begin
        if (tow_ok && cnt == 9'd10) n = 5'd4;
        if (tow_ok && cnt == 9'd12) n = 5'd3;
        case (fidx)
          5'd0: begin
            desc.kind = tsip_pkg::K_TOW;
            desc.len  = 4'd4;
          end
          5'd1: begin
            desc.kind = tsip_pkg::K_WEEK;
            desc.pos  = 8'd4;
            desc.len  = 4'd2;
          end
          5'd2: begin
            if (cnt == 9'd10) begin
              desc.kind = tsip_pkg::K_UTC;
              desc.pos  = 8'd6;
              desc.len  = 4'd4;
            end else begin
              desc.kind = tsip_pkg::K_STATUS;
            end
          end
          default: desc.kind = tsip_pkg::K_STATUS;
        endcase
      end
      tsip_pkg::RID_VEL: begin
        if (cnt == 9'd20) n = 5'd4;
        if (fidx < 5'd3) begin
          desc.kind = tsip_pkg::K_VEL;
          desc.idx  = fidx[2:0];
          desc.pos  = 8'(fidx) << 2;
          desc.len  = 4'd4;
        end else begin
          desc.kind = tsip_pkg::K_STATUS;
        end
      end
      tsip_pkg::RID_POS: begin
        if (cnt == 9'd36) n = 5'd4;
        if (fidx < 5'd3) begin
          desc.kind = tsip_pkg::K_POSN;
          desc.idx  = fidx[2:0];
          desc.pos  = 8'(fidx) << 3;
          desc.len  = 4'd8;
        end else begin
          desc.kind = tsip_pkg::K_STATUS;
        end
      end
      default: n = '0;
    endcase
    desc.last = (fidx == n - 5'd1);
    n_fields  = n;
  end

endmodule

### sv/tsip_report_deframer_decoder.sv
// DLE/ETX report deframer and field decoder. Received bytes come in one per
// transaction on the in_ channel; a byte is taken while no frame
// is being decoded. DLE DLE stores a data DLE, DLE <id> opens a frame for that
// report id, and DLE ETX closes it. Payload bytes are kept in an on-chip
// frame store (bytes past FRAME_BYTES are dropped). On DLE ETX the decoder
// reads the first four payload bytes, settles length checks and
// the status/mode state, then walks the stored bytes, one memory read per
// cycle, to build each field, then hands the field to the output register
// once that register is free or being taken. Up to
// 5 + MAX_SATS result transactions follow, the final one flagged by
// out_last_field. Float and double fields leave as their raw big-endian bits.
// Input is held off only while a frame is being decoded; the last result may
// still wait in the output register while new bytes flow in. The store has
// no reset; bytes read past its filled part are replaced by zero.
module tsip_report_deframer_decoder #(
  parameter int FRAME_BYTES = 250,
  parameter int MAX_SATS    = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_report_code,
  output logic [3:0]  out_field_kind,
  output logic [2:0]  out_field_index,
  output logic [63:0] out_field_value,
  output logic        out_last_field
);

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int AW = $clog2(FRAME_BYTES);
  localparam logic [CW-1:0] FULL = CW'(FRAME_BYTES);
  localparam logic [3:0] MAXS4 = 4'(MAX_SATS);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SETUP  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          esc_r, esc_nxt;
  logic [7:0]    fid_r, fid_nxt;
  logic [7:0]    status_r, status_nxt;
  logic [7:0]    mode_r, mode_nxt;

  // latched frame under decode
  logic [7:0]    rid_r, rid_nxt;
  logic [8:0]    fcnt_r, fcnt_nxt;
  logic [3:0]    satk_r, satk_nxt;
  logic          towok_r, towok_nxt;
  logic [4:0]    fidx_r, fidx_nxt;
  logic          hdr_r, hdr_nxt;

  // byte fetch engine
  logic [7:0]    fpos_r, fpos_nxt;
  logic [3:0]    fleft_r, fleft_nxt;
  logic          fpend_r, fpend_nxt;
  logic [7:0]    rpos_r, rpos_nxt;
  logic [63:0]   acc_r, acc_nxt;

  // output register
  logic          ov_r, ov_nxt;
  logic [7:0]    o_code_r, o_code_nxt;
  logic [3:0]    o_kind_r, o_kind_nxt;
  logic [2:0]    o_idx_r, o_idx_nxt;
  logic [63:0]   o_val_r, o_val_nxt;
  logic          o_last_r, o_last_nxt;

  // frame store
  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    mem_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;

  tsip_pkg::fdesc_t desc;
  logic [4:0]       n_fields;

  logic       in_fire;
  logic [7:0] b0;
  logic [7:0] byte_in;
  logic [7:0] m;
  logic [3:0] hi;

  tsip_field_map #(
    .MAX_SATS(MAX_SATS)
  ) u_map (
    .rid     (rid_r),
    .cnt     (fcnt_r),
    .fidx    (fidx_r),
    .sat_k   (satk_r),
    .tow_ok  (towok_r),
    .desc    (desc),
    .n_fields(n_fields)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[fpos_r[AW-1:0]];
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign b0       = acc_r[31:24];
  assign rd_en    = (state_r == S_FETCH) && (fleft_r != 4'd0);
  // bytes past the received payload read as zero
  assign byte_in  = (9'(rpos_r) < fcnt_r) ? mem_q : 8'd0;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    esc_nxt    = esc_r;
    fid_nxt    = fid_r;
    status_nxt = status_r;
    mode_nxt   = mode_r;
    rid_nxt    = rid_r;
    fcnt_nxt   = fcnt_r;
    satk_nxt   = satk_r;
    towok_nxt  = towok_r;
    fidx_nxt   = fidx_r;
    hdr_nxt    = hdr_r;
    fpos_nxt   = fpos_r;
    fleft_nxt  = fleft_r;
    fpend_nxt  = 1'b0;
    rpos_nxt   = rpos_r;
    acc_nxt    = acc_r;
    ov_nxt     = ov_r && !out_ready;
    o_code_nxt = o_code_r;
    o_kind_nxt = o_kind_r;
    o_idx_nxt  = o_idx_r;
    o_val_nxt  = o_val_r;
    o_last_nxt = o_last_r;
    wr_en      = 1'b0;
    wr_addr    = cnt_r[AW-1:0];
    wr_data    = in_rx_byte;
    m          = 8'd0;
    hi         = b0[7:4];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!esc_r) begin
            if (in_rx_byte == tsip_pkg::SYM_DLE) begin
              esc_nxt = 1'b1;
            end else if (cnt_r < FULL) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end else if (in_rx_byte == tsip_pkg::SYM_DLE) begin
            // stuffed data DLE
            esc_nxt = 1'b0;
            if (cnt_r < FULL) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end else if (in_rx_byte != tsip_pkg::SYM_ETX) begin
            // start of frame
            esc_nxt = 1'b0;
            cnt_nxt = '0;
            fid_nxt = in_rx_byte;
          end else begin
            // end of frame: latch it and fetch the header bytes
            esc_nxt   = 1'b0;
            cnt_nxt   = '0;
            fid_nxt   = 8'd0;
            rid_nxt   = fid_r;
            fcnt_nxt  = 9'(cnt_r);
            fpos_nxt  = 8'd0;
            fleft_nxt = 4'd4;
            acc_nxt   = '0;
            hdr_nxt   = 1'b1;
            state_nxt = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        if (fleft_r != 4'd0) begin
          fpend_nxt = 1'b1;
          rpos_nxt  = fpos_r;
          fpos_nxt  = fpos_r + 8'd1;
          fleft_nxt = fleft_r - 4'd1;
        end
        if (fpend_r) begin
          acc_nxt = {acc_r[55:0], byte_in};
        end
        if (fleft_r == 4'd0 && !fpend_r) begin
          state_nxt = hdr_r ? S_DECIDE : S_EMIT;
        end
      end

      S_DECIDE: begin
        hdr_nxt   = 1'b0;
        fidx_nxt  = 5'd0;
        satk_nxt  = (hi > MAXS4) ? MAXS4 : hi;
        towok_nxt = (acc_r[31:0] < tsip_pkg::TOW_LIMIT);
        state_nxt = S_SETUP;
        case (rid_r)
          tsip_pkg::RID_HEALTH: begin
            if (fcnt_r == 9'd2) begin
              status_nxt = {status_r[7:4], 4'd0} | ({4'd0, b0[3:0]} + 8'd1);
            end
          end
          tsip_pkg::RID_SATSEL: begin
            case (b0)
              8'h01:   m = 8'd1;
              8'h03:   m = 8'd2;
              8'h04:   m = 8'd3;
              8'h11:   m = 8'd4;
              8'h13:   m = 8'd5;
              8'h14:   m = 8'd6;
              default: m = 8'd0;
            endcase
            if (fcnt_r == 9'd21) mode_nxt = {mode_r[7:3], m[2:0]};
          end
          tsip_pkg::RID_ALLSV: begin
            case (b0[3:0])
              4'h3:    m = 8'd2;
              4'h4:    m = 8'd3;
              4'hB:    m = 8'd5;
              4'hC:    m = 8'd6;
              default: m = 8'd0;
            endcase
            if (fcnt_r >= 9'd17) mode_nxt = {mode_r[7:3], m[2:0]};
          end
          tsip_pkg::RID_MODE: begin
            if (fcnt_r >= 9'd1) mode_nxt = {b0[1:0], mode_r[5:0]};
          end
          tsip_pkg::RID_TIME: begin
            if ((fcnt_r == 9'd10 || fcnt_r == 9'd12) &&
                acc_r[31:0] < tsip_pkg::TOW_LIMIT) begin
              status_nxt = status_r | 8'h10;
            end
          end
          tsip_pkg::RID_VEL: begin
            if (fcnt_r == 9'd20) status_nxt = status_r | 8'h20;
          end
          tsip_pkg::RID_POS: begin
            if (fcnt_r == 9'd36) status_nxt = status_r | 8'h80;
          end
          default: m = 8'd0;
        endcase
      end

      S_SETUP: begin
        // the field count is settled once the header is latched
        if (n_fields == 5'd0) begin
          state_nxt = S_IDLE;
        end else begin
          fpos_nxt  = desc.pos;
          fleft_nxt = desc.len;
          acc_nxt   = '0;
          state_nxt = S_FETCH;
        end
      end

      S_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt     = 1'b1;
          o_code_nxt = rid_r;
          o_kind_nxt = desc.kind;
          o_idx_nxt  = desc.idx;
          o_last_nxt = desc.last;
          if (desc.kind == tsip_pkg::K_STATUS) begin
            o_val_nxt = {56'd0, status_r};
          end else if (desc.kind == tsip_pkg::K_MODE) begin
            o_val_nxt = {56'd0, mode_r};
          end else begin
            o_val_nxt = acc_r;
          end
          fidx_nxt  = fidx_r + 5'd1;
          state_nxt = desc.last ? S_IDLE : S_SETUP;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      esc_r    <= 1'b0;
      fid_r    <= 8'd0;
      status_r <= 8'd0;
      mode_r   <= 8'd0;
      hdr_r    <= 1'b0;
      fpend_r  <= 1'b0;
      fleft_r  <= 4'd0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      esc_r    <= esc_nxt;
      fid_r    <= fid_nxt;
      status_r <= status_nxt;
      mode_r   <= mode_nxt;
      hdr_r    <= hdr_nxt;
      fpend_r  <= fpend_nxt;
      fleft_r  <= fleft_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rid_r    <= rid_nxt;
    fcnt_r   <= fcnt_nxt;
    satk_r   <= satk_nxt;
    towok_r  <= towok_nxt;
    fidx_r   <= fidx_nxt;
    fpos_r   <= fpos_nxt;
    rpos_r   <= rpos_nxt;
    acc_r    <= acc_nxt;
    o_code_r <= o_code_nxt;
    o_kind_r <= o_kind_nxt;
    o_idx_r  <= o_idx_nxt;
    o_val_r  <= o_val_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid       = ov_r;
  assign out_report_code = o_code_r;
  assign out_field_kind  = o_kind_r;
  assign out_field_index = o_idx_r;
  assign out_field_value = o_val_r;
  assign out_last_field  = o_last_r;

  // a read in flight only exists while fetching
  a_pend_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    fpend_r |-> state_r == S_FETCH)
    else $error("read pending outside fetch");

  // emitting only happens for a frame with fields
  a_emit_has_fields: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> n_fields != 5'd0)
    else $error("emit without fields");

  // a finished field fetch goes straight to emit
  a_fetch_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH && fleft_r == 4'd0 && !fpend_r && !hdr_r)
      |=> state_r == S_EMIT)
    else $error("field fetch did not reach emit");

  // frame fill never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL)
    else $error("byte count beyond frame store");

endmodule

### sim/tsip_frame_checker.sv
`timescale 1ns / 100ps

module tsip_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_report_code,
  input  logic [3:0]  out_field_kind,
  input  logic [2:0]  out_field_index,
  input  logic [63:0] out_field_value,
  input  logic        out_last_field,
  output int          fail_count,
  output int          pending_fields,
  output int          fields_seen
);

  localparam int FRAME_BYTES = 250;
  localparam int MAX_SATS    = 6;

  typedef struct packed {
    logic [7:0]  code;
    logic [3:0]  kind;
    logic [2:0]  idx;
    logic [63:0] value;
    logic        last;
  } field_t;

  field_t      field_queue[$];
  logic [7:0]  store_mem[256];
  int          fill;
  logic        escaped;
  logic [7:0]  cur_id;
  logic [7:0]  status_r;
  logic [7:0]  mode_r;

  function automatic logic [7:0] byte_at(int pos);
    if (pos >= fill || pos > 255) return 8'h00;
    return store_mem[pos];
  endfunction

  function automatic logic [63:0] word_at(int pos, int len);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < len; k++) v = {v[55:0], byte_at(pos + k)};
    return v;
  endfunction

  function automatic void push_field(logic [3:0] kind, int idx, logic [63:0] value);
    field_t f;
    f.code  = cur_id;
    f.kind  = kind;
    f.idx   = 3'(idx);
    f.value = value;
    f.last  = 1'b0;
    field_queue.push_back(f);
  endfunction

  function automatic void push_sats(int first, int count);
    for (int s = 0; s < MAX_SATS; s++)
      push_field(tsip_pkg::K_SAT, s, s < count ? 64'(byte_at(first + s)) : 64'h0);
  endfunction

  function automatic void push_dops(int first);
    for (int d = 0; d < 4; d++)
      push_field(tsip_pkg::K_DOP, d, word_at(first + 4 * d, 4));
  endfunction

  // builds the field transactions of a closed frame
  function automatic void decode_report();
    int         base;
    logic [7:0] b0;
    logic [2:0] m;
    int         k;
    base = field_queue.size();
    b0   = byte_at(0);
    m    = 3'd0;
    case (cur_id)
      tsip_pkg::RID_INIT: if (fill == 10) push_field(tsip_pkg::K_INIT, 0, 64'h0);
      tsip_pkg::RID_HEALTH: if (fill == 2) begin
        status_r = (status_r & 8'hF0) | ({4'h0, b0[3:0]} + 8'd1);
        push_field(tsip_pkg::K_STATUS, 0, 64'(status_r));
        push_field(tsip_pkg::K_ERROR, 0, 64'(byte_at(1)));
      end
      tsip_pkg::RID_SATSEL: if (fill == 21) begin
        case (b0)
          8'h01: m = 3'd1;
          8'h03: m = 3'd2;
          8'h04: m = 3'd3;
          8'h11: m = 3'd4;
          8'h13: m = 3'd5;
          8'h14: m = 3'd6;
          default: m = 3'd0;
        endcase
        mode_r = {mode_r[7:3], m};
        push_field(tsip_pkg::K_MODE, 0, 64'(mode_r));
        push_sats(1, 4);
        push_dops(5);
      end
      tsip_pkg::RID_ALLSV: if (fill >= 17) begin
        case (b0[3:0])
          4'h3: m = 3'd2;
          4'h4: m = 3'd3;
          4'hB: m = 3'd5;
          4'hC: m = 3'd6;
          default: m = 3'd0;
        endcase
        mode_r = {mode_r[7:3], m};
        push_field(tsip_pkg::K_MODE, 0, 64'(mode_r));
        push_dops(1);
        k = b0[7:4];
        if (k > MAX_SATS) k = MAX_SATS;
        push_sats(17, k);
      end
      tsip_pkg::RID_MODE: if (fill >= 1) begin
        mode_r = {b0[1:0], mode_r[5:0]};
        push_field(tsip_pkg::K_MODE, 0, 64'(mode_r));
      end
      tsip_pkg::RID_TIME: if ((fill == 10 || fill == 12) &&
                              word_at(0, 4) < 64'(tsip_pkg::TOW_LIMIT)) begin
        push_field(tsip_pkg::K_TOW, 0, word_at(0, 4));
        push_field(tsip_pkg::K_WEEK, 0, word_at(4, 2));
        if (fill == 10) push_field(tsip_pkg::K_UTC, 0, word_at(6, 4));
        status_r = status_r | 8'h10;
        push_field(tsip_pkg::K_STATUS, 0, 64'(status_r));
      end
      tsip_pkg::RID_VEL: if (fill == 20) begin
        for (int a = 0; a < 3; a++) push_field(tsip_pkg::K_VEL, a, word_at(4 * a, 4));
        status_r = status_r | 8'h20;
        push_field(tsip_pkg::K_STATUS, 0, 64'(status_r));
      end
      tsip_pkg::RID_POS: if (fill == 36) begin
        for (int a = 0; a < 3; a++) push_field(tsip_pkg::K_POSN, a, word_at(8 * a, 8));
        status_r = status_r | 8'h80;
        push_field(tsip_pkg::K_STATUS, 0, 64'(status_r));
      end
      default: ;
    endcase
    if (field_queue.size() > base) field_queue[field_queue.size() - 1].last = 1'b1;
  endfunction

  function automatic void keep_byte(logic [7:0] b);
    if (fill < FRAME_BYTES) begin
      store_mem[fill] = b;
      fill++;
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (!escaped) begin
      if (b == tsip_pkg::SYM_DLE) escaped = 1'b1;
      else keep_byte(b);
    end else if (b == tsip_pkg::SYM_DLE) begin
      keep_byte(tsip_pkg::SYM_DLE);
      escaped = 1'b0;
    end else if (b != tsip_pkg::SYM_ETX) begin
      fill    = 0;
      cur_id  = b;
      escaped = 1'b0;
    end else begin
      decode_report();
      fill    = 0;
      cur_id  = 8'h00;
      escaped = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    field_t want;
    if (!rst_n) begin
      fill = 0; escaped = 1'b0; cur_id = 8'h00; status_r = 8'h00; mode_r = 8'h00;
      field_queue.delete();
      fail_count <= 0;
      fields_seen <= 0;
      pending_fields <= 0;
    end else begin
      if (in_valid && in_ready) take_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        fields_seen <= fields_seen + 1;
        if (field_queue.size() == 0) begin
          $error("unexpected field transaction kind %0d", out_field_kind);
          fail_count <= fail_count + 1;
        end else begin
          want = field_queue.pop_front();
          if (out_report_code !== want.code || out_field_kind !== want.kind ||
              out_field_index !== want.idx || out_field_value !== want.value ||
              out_last_field !== want.last) begin
            if (out_report_code !== want.code)
              $error("report_code exp %h got %h", want.code, out_report_code);
            if (out_field_kind !== want.kind)
              $error("field_kind exp %0d got %0d", want.kind, out_field_kind);
            if (out_field_index !== want.idx)
              $error("field_index exp %0d got %0d", want.idx, out_field_index);
            if (out_field_value !== want.value)
              $error("field_value exp %h got %h", want.value, out_field_value);
            if (out_last_field !== want.last)
              $error("last_field exp %b got %b", want.last, out_last_field);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_fields <= field_queue.size();
    end
  end

endmodule

### sim/tb_tsip_report_deframer_decoder.sv
`timescale 1ns / 100ps

module tb_tsip_report_deframer_decoder;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_report_code;
  logic [3:0]  out_field_kind;
  logic [2:0]  out_field_index;
  logic [63:0] out_field_value;
  logic        out_last_field;
  int          fail_count;
  int          pending_fields;
  int          fields_seen;

  // bytes queued for the sender, and a flag to hold off the receiver
  logic [7:0]  byte_stream[$];
  int          bytes_sent;
  int          frames_built;
  logic        hold_rx;
  logic        stream_done;

  tsip_report_deframer_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_report_code(out_report_code), .out_field_kind(out_field_kind),
    .out_field_index(out_field_index), .out_field_value(out_field_value),
    .out_last_field(out_last_field)
  );

  tsip_frame_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_report_code(out_report_code), .out_field_kind(out_field_kind),
    .out_field_index(out_field_index), .out_field_value(out_field_value),
    .out_last_field(out_last_field),
    .fail_count(fail_count), .pending_fields(pending_fields),
    .fields_seen(fields_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // payload byte, escaped if it is a DLE
  task automatic add_data(logic [7:0] b);
    byte_stream.push_back(b);
    if (b == tsip_pkg::SYM_DLE) byte_stream.push_back(tsip_pkg::SYM_DLE);
  endtask

  task automatic open_frame(logic [7:0] id);
    byte_stream.push_back(tsip_pkg::SYM_DLE);
    byte_stream.push_back(id);
  endtask

  task automatic close_frame();
    byte_stream.push_back(tsip_pkg::SYM_DLE);
    byte_stream.push_back(tsip_pkg::SYM_ETX);
    frames_built++;
  endtask

  // a whole report with given id, length and first byte, rest random;
  // when low_tow is set, the first tow byte is drawn from 00..49 hex
  task automatic add_report(logic [7:0] id, int len, logic [7:0] b0, bit low_tow);
    logic [7:0] b;
    open_frame(id);
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? b0 : 8'($urandom);
      if (low_tow && i == 0) b = 8'($urandom_range(8'h00, 8'h49));
      if ($urandom_range(0, 15) == 0) b = tsip_pkg::SYM_DLE;
      add_data(b);
    end
    close_frame();
  endtask

  task automatic add_random_report();
    logic [7:0] id;
    int         len;
    int         pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin id = tsip_pkg::RID_INIT;   len = 10; end
      1: begin id = tsip_pkg::RID_HEALTH; len = 2;  end
      2: begin id = tsip_pkg::RID_SATSEL; len = 21; end
      3: begin id = tsip_pkg::RID_ALLSV;  len = $urandom_range(17, 24); end
      4: begin id = tsip_pkg::RID_MODE;   len = $urandom_range(1, 4); end
      5: begin id = tsip_pkg::RID_TIME;   len = $urandom_range(0, 1) ? 10 : 12; end
      6: begin id = tsip_pkg::RID_VEL;    len = 20; end
      7: begin id = tsip_pkg::RID_POS;    len = 36; end
      8: begin id = 8'($urandom); len = $urandom_range(0, 12); end
      default: begin id = tsip_pkg::RID_ALLSV; len = $urandom_range(0, 16); end
    endcase
    if (id == tsip_pkg::SYM_DLE || id == tsip_pkg::SYM_ETX) id = tsip_pkg::RID_INIT;
    // sometimes a wrong length
    if (pick < 8 && $urandom_range(0, 7) == 0) len = len + 1;
    add_report(id, len, 8'($urandom),
               id == tsip_pkg::RID_TIME && $urandom_range(0, 1) == 1);
  endtask

  // sender: bursts with random gaps
  initial begin
    int burst;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    bytes_sent  = 0;
    stream_done = 1'b0;
    wait (rst_n === 1'b1);
    while (byte_stream.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && byte_stream.size() > 0) begin
        in_valid   <= 1'b1;
        in_rx_byte <= byte_stream.pop_front();
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
        burst--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    in_valid    <= 1'b0;
    stream_done <= 1'b1;
  end

  // receiver: its own stall pattern, plus a long hold-off when asked
  initial begin
    int mode_sel;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      mode_sel = $urandom_range(0, 99);
      if (hold_rx) out_ready <= 1'b0;
      else if (fields_seen % 64 < 16) out_ready <= 1'b1;
      else out_ready <= (mode_sel < 60);
    end
  end

  // long output stall while the sender keeps pushing report bytes
  initial begin
    hold_rx = 1'b0;
    wait (rst_n === 1'b1);
    wait (bytes_sent > 270);
    hold_rx = 1'b1;
    repeat (600) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    int wait_cycles;
    frames_built = 0;
    rst_n = 1'b0;

    // overlong frame: two data bytes past the store are dropped
    open_frame(tsip_pkg::RID_POS);
    for (int i = 0; i < 252; i++) add_data(8'($urandom));
    close_frame();
    // directed special cases
    add_report(tsip_pkg::RID_HEALTH, 2, 8'hFF, 0);
    add_report(tsip_pkg::RID_ALLSV, 17, 8'hFC, 0);          // sat count clamped
    add_report(tsip_pkg::RID_ALLSV, 20, 8'h43, 0);          // sats beyond payload
    add_report(tsip_pkg::RID_TIME, 10, 8'h00, 1);
    add_report(tsip_pkg::RID_TIME, 12, 8'hFF, 0);           // tow rejected
    add_report(8'h77, 3, 8'h55, 0);                         // unknown id
    // tow at exactly the limit
    open_frame(tsip_pkg::RID_TIME);
    add_data(8'h49); add_data(8'h13); add_data(8'hA8); add_data(8'h00);
    for (int i = 0; i < 6; i++) add_data(8'hAA);
    close_frame();
    // bare etx, plus stray bytes outside a frame
    byte_stream.push_back(8'hA5);
    byte_stream.push_back(8'h5A);
    close_frame();

    // random part: mostly well-formed reports, some noise
    while (byte_stream.size() < 390) begin
      if ($urandom_range(0, 9) == 0) byte_stream.push_back(8'($urandom));
      else add_random_report();
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (stream_done === 1'b1);
    wait_cycles = 0;
    while (pending_fields != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);

    $display("sent %0d bytes in %0d frames, checked %0d field transactions",
             bytes_sent, frames_built, fields_seen);
    if (fail_count == 0 && pending_fields == 0) begin
      $display("tb_tsip_report_deframer_decoder: PASS");
    end else begin
      $display("tb_tsip_report_deframer_decoder: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb_tsip_report_deframer_decoder: FAIL");
    $finish;
  end

endmodule
